@@ design/cht_pkg.sv @@
// Shared types, constants and helpers of the chained hash table engine.
package cht_pkg;

	localparam int TABLE_ENTRIES = 512;
	localparam int MAX_BUCKETS   = 256;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int LINK_W        = 10;
	localparam int BKT_W         = $clog2(MAX_BUCKETS);
	localparam int CNT_W         = $clog2(MAX_BUCKETS + 1);
	localparam int STEP_W        = $clog2(TABLE_ENTRIES + 1);
	localparam int KEY_W         = 32;
	localparam int VAL_W         = 32;

	localparam logic [LINK_W-1:0] LINK_END = '1;
	// x / 17 == (x * MAGIC) >> 36 for every 32-bit x
	localparam logic [KEY_W-1:0]  DIV17_MAGIC = 32'hF0F0F0F1;
	localparam int                DIV17_SHIFT = 36;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_FND  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NULL_KEY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_ACCEPT,
		CMD_SWEEP,
		CMD_HASH,
		CMD_DIV,
		CMD_RD_HEAD,
		CMD_HEAD,
		CMD_WALK_RD,
		CMD_WALK_CHK,
		CMD_ALLOC_RD,
		CMD_ALLOC_WR,
		CMD_LINK_HEAD,
		CMD_RM_COPY,
		CMD_RM_FREE,
		CMD_RESP
	} cmd_t;

	typedef struct packed {
		kind_t in_kind;
		logic  in_key_zero;
		kind_t kind;
		logic  hash_done;
		logic  div_done;
		logic  head_empty;
		logic  head_match;
		logic  head_link_ok;
		logic  walk_end;
		logic  walk_match;
		logic  free_ok;
		logic  sweep_done;
		logic  out_free;
	} dp_stat_t;

	function automatic logic link_ok(input logic [LINK_W-1:0] p);
		return p < LINK_W'(TABLE_ENTRIES);
	endfunction

	function automatic logic [CNT_W-1:0] clamp_buckets(input logic [8:0] v);
		logic [CNT_W-1:0] r;
		if (v == 9'd0)
			r = CNT_W'(1);
		else if (32'(v) > MAX_BUCKETS)
			r = CNT_W'(MAX_BUCKETS);
		else
			r = CNT_W'(v);
		return r;
	endfunction

endpackage

@@ design/chained_hash_table_engine.sv @@
// Top level of the chained hash table engine: controller plus datapath.
//
// Key/value table with 32-bit keys. One command word enters on the s_ side
// (s_tuser = operation: insert, remove, lookup, clear; s_tdata = key and
// value) and exactly one result word leaves on the m_ side (m_tuser = status,
// m_tdata = value read by a lookup, zero otherwise).
// The bucket is found by xoring the key with its successive quotients by 17
// (one divide step per cycle, up to 8) and then a bit-serial remainder by the
// active bucket count, over all 32 bits of the hash. The chain is then
// walked through the table memories, a read state and a check state per
// entry visited, because each memory read is registered. After reset the
// block runs an initialization pass over all 512 table entries and accepts
// no word until it finishes; a clear command runs the same pass.
// bucket_count is written through bucket_count_wen at any idle time and is
// latched as the active count at the next clear.
// The result sits in an output register: while the receiver stalls, the
// block holds that word and can take the next command, but finishes it only
// when the output register frees up.
module chained_hash_table_engine import cht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,          // key [31:0], write_value [63:32]
	input  logic [1:0]  s_tuser,          // kind [1:0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,          // read_value [31:0]
	output logic [1:0]  m_tuser,          // status [1:0]
	// configuration
	input  logic        bucket_count_wen,
	input  logic [8:0]  bucket_count
);

	cmd_t     cmd;
	dp_stat_t stat;

	// sequence the operation
	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hash, walk and update the table; hold the result word
	cht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_kind     (s_tuser),
		.in_key      (s_tdata[31:0]),
		.in_value    (s_tdata[63:32]),
		.cfg_we      (bucket_count_wen),
		.cfg_buckets (bucket_count),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_value   (m_tdata)
	);

endmodule

@@ design/cht_ram.sv @@
// Generic simple dual-port RAM with registered read.
module cht_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/cht_dp.sv @@
// Datapath: hash unit, bucket divider, table memories, pointers and result register.
module cht_dp import cht_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output dp_stat_t           stat,
	input  logic [1:0]         in_kind,
	input  logic [KEY_W-1:0]   in_key,
	input  logic [VAL_W-1:0]   in_value,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_buckets,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_status,
	output logic [VAL_W-1:0]   out_value
);

	logic [8:0]        bucket_count_q;
	logic [CNT_W-1:0]  active_q;
	logic [LINK_W-1:0] free_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              out_valid_q;

	kind_t             kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  val_q;
	logic [KEY_W-1:0]  p_q;
	logic [KEY_W-1:0]  h_q;
	logic [BKT_W-1:0]  rem_q;
	logic [4:0]        div_cnt_q;
	logic [LINK_W-1:0] hl_q;
	logic [LINK_W-1:0] pos_q;
	logic [LINK_W-1:0] prev_q;
	logic [STEP_W-1:0] steps_q;
	status_t           status_q;
	logic [VAL_W-1:0]  rv_q;
	logic [1:0]        out_status_q;
	logic [VAL_W-1:0]  out_value_q;

	logic [2*KEY_W-1:0] prod;
	logic [BKT_W:0]     rem_sh;
	logic [BKT_W:0]     rem_n;
	logic [LINK_W-1:0]  bucket_ptr;
	logic               out_free;

	logic [ADDR_W-1:0] raddr, waddr;
	logic              key_we, data_we, link_we;
	logic [KEY_W-1:0]  key_wd, rd_key;
	logic [VAL_W-1:0]  data_wd, rd_data;
	logic [LINK_W-1:0] link_wd, rd_link;
	logic [LINK_W-1:0] sweep_ptr;
	logic [LINK_W-1:0] sweep_link;

	assign prod       = 64'(p_q) * 64'(DIV17_MAGIC);
	assign rem_sh     = {rem_q, h_q[div_cnt_q]};
	assign rem_n      = (rem_sh >= (BKT_W+1)'(active_q)) ? rem_sh - (BKT_W+1)'(active_q) : rem_sh;
	assign bucket_ptr = LINK_W'(rem_q);
	assign out_free   = !out_valid_q || out_ready;
	assign sweep_ptr  = LINK_W'(sweep_q);

	always_comb begin
		if (sweep_ptr < LINK_W'(active_q))
			sweep_link = LINK_END;
		else if (sweep_q == ADDR_W'(TABLE_ENTRIES - 1))
			sweep_link = LINK_END;
		else
			sweep_link = sweep_ptr + LINK_W'(1);
	end

	always_comb begin
		stat.in_kind      = kind_t'(in_kind);
		stat.in_key_zero  = (in_key == '0);
		stat.kind         = kind_q;
		stat.hash_done    = (p_q == '0);
		stat.div_done     = (div_cnt_q == '0);
		stat.head_empty   = (rd_key == '0);
		stat.head_match   = (rd_key == key_q);
		stat.head_link_ok = link_ok(rd_link);
		stat.walk_end     = !link_ok(pos_q) || (steps_q == STEP_W'(TABLE_ENTRIES));
		stat.walk_match   = (rd_key == key_q);
		stat.free_ok      = link_ok(free_q);
		stat.sweep_done   = (sweep_q == ADDR_W'(TABLE_ENTRIES - 1));
		stat.out_free     = out_free;
	end

	// memory port steering
	always_comb begin
		raddr   = pos_q[ADDR_W-1:0];
		waddr   = bucket_ptr[ADDR_W-1:0];
		key_we  = 1'b0;
		data_we = 1'b0;
		link_we = 1'b0;
		key_wd  = key_q;
		data_wd = val_q;
		link_wd = LINK_END;
		unique case (cmd)
			CMD_SWEEP: begin
				waddr   = sweep_q;
				key_we  = 1'b1;
				key_wd  = '0;
				link_we = 1'b1;
				link_wd = sweep_link;
			end
			CMD_RD_HEAD: begin
				raddr = bucket_ptr[ADDR_W-1:0];
			end
			CMD_HEAD: begin
				raddr = rd_link[ADDR_W-1:0];
				unique case (kind_q)
					KIND_INSERT: begin
						if (rd_key == '0) begin
							key_we  = 1'b1;
							data_we = 1'b1;
							link_we = 1'b1;
						end else if (rd_key == key_q) begin
							data_we = 1'b1;
						end
					end
					KIND_REMOVE: begin
						if (rd_key != '0 && rd_key == key_q && !link_ok(rd_link)) begin
							key_we = 1'b1;
							key_wd = '0;
						end
					end
					default: ;
				endcase
			end
			CMD_WALK_CHK: begin
				if (rd_key == key_q) begin
					if (kind_q == KIND_INSERT) begin
						waddr   = pos_q[ADDR_W-1:0];
						data_we = 1'b1;
					end else if (kind_q == KIND_REMOVE) begin
						waddr   = prev_q[ADDR_W-1:0];
						link_we = 1'b1;
						link_wd = rd_link;
					end
				end
			end
			CMD_ALLOC_RD: begin
				raddr = free_q[ADDR_W-1:0];
			end
			CMD_ALLOC_WR: begin
				waddr   = free_q[ADDR_W-1:0];
				key_we  = 1'b1;
				data_we = 1'b1;
				link_we = 1'b1;
				link_wd = hl_q;
			end
			CMD_LINK_HEAD: begin
				link_we = 1'b1;
				link_wd = pos_q;
			end
			CMD_RM_COPY: begin
				key_we  = 1'b1;
				data_we = 1'b1;
				link_we = 1'b1;
				key_wd  = rd_key;
				data_wd = rd_data;
				link_wd = rd_link;
			end
			CMD_RM_FREE: begin
				waddr   = pos_q[ADDR_W-1:0];
				link_we = 1'b1;
				link_wd = free_q;
			end
			default: ;
		endcase
	end

	cht_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wd),
		.raddr(raddr), .rdata(rd_key)
	);

	cht_ram #(.WIDTH(VAL_W), .DEPTH(TABLE_ENTRIES)) u_data_ram (
		.clk(clk), .we(data_we), .waddr(waddr), .wdata(data_wd),
		.raddr(raddr), .rdata(rd_data)
	);

	cht_ram #(.WIDTH(LINK_W), .DEPTH(TABLE_ENTRIES)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(waddr), .wdata(link_wd),
		.raddr(raddr), .rdata(rd_link)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= 9'(MAX_BUCKETS);
			active_q       <= clamp_buckets(9'(MAX_BUCKETS));
			free_q         <= LINK_END;
			sweep_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				bucket_count_q <= cfg_buckets;
			end
			if (cmd == CMD_ACCEPT && kind_t'(in_kind) == KIND_CLEAR) begin
				active_q <= clamp_buckets(bucket_count_q);
				sweep_q  <= '0;
			end
			if (cmd == CMD_SWEEP) begin
				sweep_q <= sweep_q + ADDR_W'(1);
				if (sweep_q == ADDR_W'(TABLE_ENTRIES - 1)) begin
					free_q <= (32'(active_q) < TABLE_ENTRIES) ? LINK_W'(active_q) : LINK_END;
				end
			end
			if (cmd == CMD_ALLOC_WR) begin
				free_q <= rd_link;
			end
			if (cmd == CMD_RM_FREE) begin
				free_q <= pos_q;
			end
			if (cmd == CMD_RESP) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		unique case (cmd)
			CMD_ACCEPT: begin
				kind_q   <= kind_t'(in_kind);
				key_q    <= in_key;
				val_q    <= in_value;
				p_q      <= in_key;
				h_q      <= '0;
				rv_q     <= '0;
				status_q <= (kind_t'(in_kind) != KIND_CLEAR && in_key == '0) ? ST_NULL_KEY : ST_OK;
			end
			CMD_HASH: begin
				if (p_q != '0) begin
					h_q <= h_q ^ p_q;
					p_q <= KEY_W'(prod[2*KEY_W-1:DIV17_SHIFT]);
				end else begin
					rem_q     <= '0;
					div_cnt_q <= 5'(KEY_W - 1);
				end
			end
			CMD_DIV: begin
				rem_q     <= rem_n[BKT_W-1:0];
				div_cnt_q <= div_cnt_q - 5'd1;
			end
			CMD_HEAD: begin
				hl_q    <= rd_link;
				pos_q   <= rd_link;
				prev_q  <= bucket_ptr;
				steps_q <= (kind_q == KIND_REMOVE) ? STEP_W'(0) : STEP_W'(1);
				if (rd_key == '0 && kind_q != KIND_INSERT) begin
					status_q <= ST_NOT_FND;
				end
				if (rd_key != '0 && rd_key == key_q && kind_q == KIND_LOOKUP) begin
					rv_q <= rd_data;
				end
			end
			CMD_WALK_RD: begin
				if (stat.walk_end && kind_q != KIND_INSERT) begin
					status_q <= ST_NOT_FND;
				end
			end
			CMD_WALK_CHK: begin
				if (rd_key == key_q) begin
					if (kind_q == KIND_LOOKUP) begin
						rv_q <= rd_data;
					end
				end else begin
					prev_q  <= pos_q;
					pos_q   <= rd_link;
					steps_q <= steps_q + STEP_W'(1);
				end
			end
			CMD_ALLOC_RD: begin
				if (!link_ok(free_q)) begin
					status_q <= ST_FULL;
				end
			end
			CMD_ALLOC_WR: begin
				pos_q <= free_q;
			end
			CMD_RESP: begin
				out_status_q <= status_q;
				out_value_q  <= rv_q;
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;

	a_alloc_free_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_ALLOC_WR |-> link_ok(free_q))
		else $error("allocation from an empty free list");

	a_resp_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_RESP |-> out_free)
		else $error("result loaded over an untaken result");

	a_link_after_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_LINK_HEAD |-> $past(cmd) == CMD_ALLOC_WR)
		else $error("head relinked without a fresh entry");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd == CMD_DIV |-> CNT_W'(rem_q) < active_q)
		else $error("bucket remainder out of range");

endmodule

@@ design/cht_ctrl.sv @@
// Controller state machine that sequences the table datapath.
module cht_ctrl import cht_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output cmd_t     cmd
);

	typedef enum logic [14:0] {
		S_INIT     = 15'b000000000000001,
		S_IDLE     = 15'b000000000000010,
		S_CLEAR    = 15'b000000000000100,
		S_HASH     = 15'b000000000001000,
		S_DIV      = 15'b000000000010000,
		S_RD_HEAD  = 15'b000000000100000,
		S_HEAD     = 15'b000000001000000,
		S_WALK_RD  = 15'b000000010000000,
		S_WALK_CHK = 15'b000000100000000,
		S_ALLOC_RD = 15'b000001000000000,
		S_ALLOC_WR = 15'b000010000000000,
		S_LINK_HD  = 15'b000100000000000,
		S_RM_COPY  = 15'b001000000000000,
		S_RM_FREE  = 15'b010000000000000,
		S_RESP     = 15'b100000000000000
	} state_t;

	state_t state_q, state_n;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_n = state_q;
		cmd     = CMD_NONE;
		unique case (state_q)
			S_INIT: begin
				cmd = CMD_SWEEP;
				if (stat.sweep_done) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd = CMD_ACCEPT;
					if (stat.in_kind == KIND_CLEAR) state_n = S_CLEAR;
					else if (stat.in_key_zero)      state_n = S_RESP;
					else                            state_n = S_HASH;
				end
			end
			S_CLEAR: begin
				cmd = CMD_SWEEP;
				if (stat.sweep_done) state_n = S_RESP;
			end
			S_HASH: begin
				cmd = CMD_HASH;
				if (stat.hash_done) state_n = S_DIV;
			end
			S_DIV: begin
				cmd = CMD_DIV;
				if (stat.div_done) state_n = S_RD_HEAD;
			end
			S_RD_HEAD: begin
				cmd     = CMD_RD_HEAD;
				state_n = S_HEAD;
			end
			S_HEAD: begin
				cmd = CMD_HEAD;
				priority if (stat.head_empty)
					state_n = S_RESP;
				else if (stat.head_match && stat.kind == KIND_REMOVE && stat.head_link_ok)
					state_n = S_RM_COPY;
				else if (stat.head_match)
					state_n = S_RESP;
				else
					state_n = S_WALK_RD;
			end
			S_WALK_RD: begin
				cmd = CMD_WALK_RD;
				priority if (!stat.walk_end)          state_n = S_WALK_CHK;
				else if (stat.kind == KIND_INSERT)    state_n = S_ALLOC_RD;
				else                                  state_n = S_RESP;
			end
			S_WALK_CHK: begin
				cmd = CMD_WALK_CHK;
				priority if (!stat.walk_match)        state_n = S_WALK_RD;
				else if (stat.kind == KIND_REMOVE)    state_n = S_RM_FREE;
				else                                  state_n = S_RESP;
			end
			S_ALLOC_RD: begin
				cmd     = CMD_ALLOC_RD;
				state_n = stat.free_ok ? S_ALLOC_WR : S_RESP;
			end
			S_ALLOC_WR: begin
				cmd     = CMD_ALLOC_WR;
				state_n = S_LINK_HD;
			end
			S_LINK_HD: begin
				cmd     = CMD_LINK_HEAD;
				state_n = S_RESP;
			end
			S_RM_COPY: begin
				cmd     = CMD_RM_COPY;
				state_n = S_RM_FREE;
			end
			S_RM_FREE: begin
				cmd     = CMD_RM_FREE;
				state_n = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd     = CMD_RESP;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_n;
		end
	end

endmodule

@@ bench/tb_chained_hash_table_engine.sv @@
// Self-checking testbench of the chained hash table engine: random and directed commands.
`timescale 1ns / 100ps

module tb_chained_hash_table_engine import cht_pkg::*;;

	localparam int HALF_PERIOD = 5;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 600; // covers a clear pass over all 512 table entries and the result

	// Software copy of the table that predicts each result word.
	class table_scoreboard;
		logic [31:0] slot_key [TABLE_ENTRIES];
		logic [31:0] slot_data [TABLE_ENTRIES];
		logic [15:0] slot_next [TABLE_ENTRIES];
		logic [15:0] free_top;
		int unsigned live_buckets;
		logic [8:0] pending_buckets;
		status_t want_status [$];
		logic [31:0] want_value [$];
		int errors;

		function new();
			errors = 0;
			pending_buckets = 9'd256;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				slot_key[i] = '0;
				slot_data[i] = '0;
			end
			rebuild();
		endfunction

		function void rebuild();
			int unsigned b;
			b = pending_buckets;
			if (b < 1) b = 1;
			if (b > MAX_BUCKETS) b = MAX_BUCKETS;
			live_buckets = b;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (i < b) begin
					slot_key[i] = '0;
					slot_next[i] = 16'hFFFF;
				end else begin
					slot_next[i] = (i + 1 < TABLE_ENTRIES) ? 16'(i + 1) : 16'hFFFF;
				end
			end
			free_top = (b < TABLE_ENTRIES) ? 16'(b) : 16'hFFFF;
		endfunction

		function int unsigned bucket_of(logic [31:0] key);
			logic [31:0] h;
			logic [31:0] p;
			h = '0;
			p = key;
			while (p != 0) begin
				h ^= p;
				p = p / 32'd17;
			end
			return h % live_buckets;
		endfunction

		function logic [15:0] locate(int unsigned head, logic [31:0] key);
			logic [15:0] pos;
			int steps;
			pos = 16'(head);
			steps = 0;
			if (slot_key[head] == 0) return 16'hFFFF;
			while (pos < TABLE_ENTRIES && steps < TABLE_ENTRIES) begin
				if (slot_key[pos] == key) return pos;
				pos = slot_next[pos];
				steps++;
			end
			return 16'hFFFF;
		endfunction

		function status_t insert_key(logic [31:0] key, logic [31:0] val);
			int unsigned h;
			logic [15:0] pos;
			h = bucket_of(key);
			if (slot_key[h] == 0) begin
				slot_key[h] = key;
				slot_data[h] = val;
				slot_next[h] = 16'hFFFF;
				return ST_OK;
			end
			pos = locate(h, key);
			if (pos != 16'hFFFF) begin
				slot_data[pos] = val;
				return ST_OK;
			end
			if (free_top >= TABLE_ENTRIES) return ST_FULL;
			pos = free_top;
			free_top = slot_next[pos];
			slot_next[pos] = slot_next[h];
			slot_key[pos] = key;
			slot_data[pos] = val;
			slot_next[h] = pos;
			return ST_OK;
		endfunction

		function status_t remove_key(logic [31:0] key);
			int unsigned h;
			logic [15:0] pos;
			logic [15:0] prev;
			int steps;
			h = bucket_of(key);
			steps = 0;
			if (slot_key[h] == 0) return ST_NOT_FND;
			if (slot_key[h] == key) begin
				pos = slot_next[h];
				if (pos < TABLE_ENTRIES) begin
					slot_key[h] = slot_key[pos];
					slot_data[h] = slot_data[pos];
					slot_next[h] = slot_next[pos];
					slot_next[pos] = free_top;
					free_top = pos;
				end else begin
					slot_key[h] = '0;
				end
				return ST_OK;
			end
			prev = 16'(h);
			pos = slot_next[h];
			while (pos < TABLE_ENTRIES && steps < TABLE_ENTRIES) begin
				if (slot_key[pos] == key) begin
					slot_next[prev] = slot_next[pos];
					slot_next[pos] = free_top;
					free_top = pos;
					return ST_OK;
				end
				prev = pos;
				pos = slot_next[pos];
				steps++;
			end
			return ST_NOT_FND;
		endfunction

		// Note one accepted command word and queue its result.
		function void note_command(kind_t kind, logic [31:0] key, logic [31:0] val);
			status_t st;
			logic [31:0] rv;
			logic [15:0] pos;
			st = ST_OK;
			rv = '0;
			if (kind == KIND_CLEAR) begin
				rebuild();
			end else if (key == 0) begin
				st = ST_NULL_KEY;
			end else if (kind == KIND_INSERT) begin
				st = insert_key(key, val);
			end else if (kind == KIND_REMOVE) begin
				st = remove_key(key);
			end else begin
				pos = locate(bucket_of(key), key);
				if (pos != 16'hFFFF) rv = slot_data[pos];
				else st = ST_NOT_FND;
			end
			want_status.push_back(st);
			want_value.push_back(rv);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		// Compare one result word with the oldest queued result.
		task check_result(logic [1:0] st, logic [31:0] rv);
			status_t es;
			logic [31:0] ev;
			if (want_status.size() == 0) begin
				report($sformatf("unexpected result status=%0d value=%h", st, rv));
			end else begin
				es = want_status.pop_front();
				ev = want_value.pop_front();
				if (st !== es)
					report($sformatf("status %0d, want %0d", st, es));
				if (rv !== ev)
					report($sformatf("read_value %h, want %h", rv, ev));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        bucket_count_wen;
	logic [8:0]  bucket_count;

	table_scoreboard sb;
	int sender_idle_pct;
	int receiver_stall_pct;
	int cycles;
	logic [31:0] key_pool [24];

	chained_hash_table_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.bucket_count_wen(bucket_count_wen),
		.bucket_count(bucket_count)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Watchdog: end the run if the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Receiver side: check each result word, stall at random.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tuser, m_tdata);
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Drive one command word and hold it until the block accepts it.
	task send_command(kind_t kind, logic [31:0] key, logic [31:0] val);
		if ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {val, key};
		do @(posedge clk); while (!s_tready);
		sb.note_command(kind, key, val);
	endtask

	// Drop valid and wait until every queued result has come back.
	task drain;
		@(posedge clk);
		s_tvalid <= 1'b0;
		while (sb.want_status.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Write the bucket count register; called only between bursts of command traffic.
	task write_buckets(logic [8:0] v);
		@(posedge clk);
		bucket_count_wen <= 1'b1;
		bucket_count <= v;
		@(posedge clk);
		bucket_count_wen <= 1'b0;
		bucket_count <= 9'($urandom);
		sb.pending_buckets = v;
	endtask

	task random_key(output logic [31:0] key);
		int r;
		r = $urandom_range(99);
		if (r < 6) key = '0;
		else if (r < 90) key = key_pool[$urandom_range(23)];
		else key = $urandom;
	endtask

	// Mostly well-formed traffic over a small key pool so chains form and get hit.
	task random_traffic(int count);
		int r;
		logic [31:0] key;
		for (int i = 0; i < 24; i++)
			key_pool[i] = ($urandom_range(1) != 0) ? $urandom : $urandom_range(1, 400);
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			random_key(key);
			if (r < 42) send_command(KIND_INSERT, key, $urandom);
			else if (r < 70) send_command(KIND_LOOKUP, key, $urandom);
			else if (r < 97) send_command(KIND_REMOVE, key, $urandom);
			else send_command(KIND_CLEAR, $urandom, $urandom);
		end
	endtask

	// Chain keys of one bucket until the whole overflow region is used, then run
	// into a full table.
	task fill_table;
		logic [31:0] chain_keys [TABLE_ENTRIES];
		int found;
		int need;
		int unsigned target;
		logic [31:0] k;
		found = 0;
		need = TABLE_ENTRIES - int'(sb.live_buckets) + 4;
		k = 1;
		target = sb.bucket_of(32'd1);
		while (found < need) begin
			if (sb.bucket_of(k) == target) begin
				chain_keys[found] = k;
				found++;
			end
			k++;
		end
		for (int i = 0; i < found; i++)
			send_command(KIND_INSERT, chain_keys[i], $urandom);
		// overwrite still works on a full table
		send_command(KIND_INSERT, chain_keys[5], 32'hA5A5_5A5A);
		send_command(KIND_LOOKUP, chain_keys[5], '0);
		send_command(KIND_REMOVE, chain_keys[0], '0);
		send_command(KIND_INSERT, chain_keys[found-1], 32'h1234_5678);
		send_command(KIND_INSERT, chain_keys[found-2], 32'h1234_5678);
		send_command(KIND_LOOKUP, chain_keys[found-1], '0);
	endtask

	task directed;
		// two buckets: keys 1, 3, 5 and 7 chain in bucket one
		send_command(KIND_INSERT, 32'd0, 32'hFFFF_FFFF);
		send_command(KIND_LOOKUP, 32'd0, '0);
		send_command(KIND_REMOVE, 32'd0, '0);
		send_command(KIND_INSERT, 32'd1, 32'h1111_1111);
		send_command(KIND_INSERT, 32'd3, 32'h3333_3333);
		send_command(KIND_INSERT, 32'd5, 32'h5555_5555);
		send_command(KIND_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, '0);
		send_command(KIND_INSERT, 32'd3, 32'h0000_0000);
		send_command(KIND_LOOKUP, 32'd3, '0);
		send_command(KIND_LOOKUP, 32'd7, '0);
		send_command(KIND_REMOVE, 32'd7, '0);
		send_command(KIND_REMOVE, 32'd1, '0);
		send_command(KIND_LOOKUP, 32'd1, '0);
		send_command(KIND_LOOKUP, 32'd5, '0);
		send_command(KIND_REMOVE, 32'd3, '0);
		send_command(KIND_REMOVE, 32'd5, '0);
		send_command(KIND_REMOVE, 32'd5, '0);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, '0);
		send_command(KIND_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_command(KIND_LOOKUP, 32'hFFFF_FFFF, '0);
		send_command(KIND_LOOKUP, 32'd3, '0);
	endtask

	initial begin
		logic [8:0] plan [8];
		sb = new();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_INSERT;
		m_tready = 1'b0;
		bucket_count_wen = 1'b0;
		bucket_count = 9'd256;
		plan = '{9'd2, 9'd256, 9'd1, 9'd0, 9'd511, 9'd17, 9'($urandom_range(1, 255)), 9'd256};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 8; ph++) begin
			// rotate the idling mode: none, sender, receiver, both
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 53; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 53; end
				default: begin sender_idle_pct = 10; receiver_stall_pct = 10; end
			endcase
			write_buckets(plan[ph]);
			send_command(KIND_CLEAR, $urandom, $urandom);
			if (ph == 0) directed();
			if (ph == 1) fill_table();
			random_traffic(26);
			drain();
			// the register only takes effect at the next clear
			write_buckets(9'($urandom));
			random_traffic(6);
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.want_status.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ filelist.f @@
design/cht_pkg.sv
design/cht_ram.sv
design/cht_dp.sv
design/cht_ctrl.sv
design/chained_hash_table_engine.sv
bench/tb_chained_hash_table_engine.sv
